// ===== rtl/core/fan_curve_interpolator_macros.svh =====
// Assertion helpers shared by the fan curve interpolator modules.
// Each use expects signals named clk and arst_n in the enclosing module.
`ifndef FAN_CURVE_INTERPOLATOR_MACROS_SVH
`define FAN_CURVE_INTERPOLATOR_MACROS_SVH

// Condition and consequence in the same cycle, off while in reset
`define FCI_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequence must hold in the cycle after the condition
`define FCI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/fci_pkg.sv =====
package fci_pkg;

	// Table geometry
	localparam int POINTS     = 16;
	localparam int DUTY_STEP  = 16;  // power of two: divisions become shifts
	localparam int DUTY_SHIFT = $clog2(DUTY_STEP);
	localparam int IDX_W      = $clog2(POINTS);

	// Field widths
	localparam int OPCODE_W   = 2;
	localparam int ENTRY_W    = 4;
	localparam int SPEED_W    = 16;
	localparam int DEMAND_W   = 17;
	localparam int DUTY_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int FRAC_W     = 16;

	// Datapath widths
	localparam int PROD_W      = SPEED_W + 1 + DEMAND_W + 1;   // (max-min)*demand
	localparam int T_W         = 36;                            // target, Q.16 signed
	localparam int ANUM_W      = T_W - 1;                       // |T - table[lo]<<16|
	localparam int N_W         = ANUM_W + 2;                    // 2|num| + den
	localparam int A_W         = N_W - (FRAC_W + 1);            // N / 2^17
	localparam int SLOPE_W     = SPEED_W - DUTY_SHIFT;          // |slope|
	localparam int QUO_W       = 9;                             // enough to reach saturation
	localparam int REM_W       = SLOPE_W;
	localparam int DIV_CNT_W   = $clog2(QUO_W);
	localparam int DUTY_CALC_W = 12;
	localparam int P2_W        = DUTY_SHIFT + 1 + SPEED_W + 1;  // f * (th - tl)

	localparam logic [IDX_W-1:0]     IDX_LAST = IDX_W'(POINTS - 1);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUO_W - 1);

	// Opcodes
	localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_DUTY  = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_SPEED = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_DUTY = 2'd2;

	// Controller states
	typedef enum logic [4:0] {
		ST_IDLE, ST_MUL, ST_TGT, ST_CHK, ST_SRD, ST_SCMP, ST_RDL, ST_RDH,
		ST_SLP, ST_DEC, ST_ABS, ST_PREP, ST_DCHK, ST_DIV, ST_FIN1, ST_FIN2,
		ST_DONE
	} state_t;

	// Datapath operations
	typedef enum logic [4:0] {
		STEP_NONE, STEP_LOAD, STEP_MUL, STEP_TGT, STEP_SRD, STEP_SCMP,
		STEP_RDL, STEP_RDH, STEP_SLP, STEP_DEC, STEP_ABS, STEP_PREP,
		STEP_DCHK, STEP_DIV, STEP_FIN1, STEP_FIN2
	} step_t;

	typedef struct packed {
		step_t step;
		logic  out_load;
	} cmd_t;

	typedef struct packed {
		logic t_zero;     // target speed is zero
		logic more;       // search bracket still wider than one step
		logic more_nxt;   // same, for the bracket after this compare
		logic s_zero;     // slope truncates to zero
		logic op_speed;   // item is a speed-from-duty request
		logic div_last;   // last divider step
	} sts_t;

	function automatic logic [DUTY_W-1:0] sat_duty(input logic signed [DUTY_CALC_W-1:0] d);
		logic [DUTY_W-1:0] r;
		if (d < 0)
			r = '0;
		else if (d > $signed(DUTY_CALC_W'(255)))
			r = '1;
		else
			r = d[DUTY_W-1:0];
		return r;
	endfunction

endpackage

// ===== rtl/core/fci_if.sv =====
// Request channel: one table write or lookup per transfer
interface fci_req_if;
	import fci_pkg::*;
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [ENTRY_W-1:0]  entry_index;
	logic [SPEED_W-1:0]  entry_speed;
	logic [DEMAND_W-1:0] demand;
	logic [DUTY_W-1:0]   duty_in;

	modport source (output valid, opcode, entry_index, entry_speed, demand, duty_in,
		input ready);
	modport sink (input valid, opcode, entry_index, entry_speed, demand, duty_in,
		output ready);
endinterface

// Result channel
interface fci_rsp_if;
	import fci_pkg::*;
	logic               valid;
	logic               ready;
	logic [DUTY_W-1:0]  duty_out;
	logic [SPEED_W-1:0] speed_out;

	modport source (output valid, duty_out, speed_out, input ready);
	modport sink (input valid, duty_out, speed_out, output ready);
endinterface

// Configuration write channel
interface fci_cfg_if;
	import fci_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/fci_ram.sv =====
module fci_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/fci_ctrl.sv =====
`include "fan_curve_interpolator_macros.svh"

module fci_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	input  logic [fci_pkg::OPCODE_W-1:0] req_opcode,
	output logic                     req_ready,
	output logic                     rsp_valid,
	input  logic                     rsp_ready,
	input  fci_pkg::sts_t            sts,
	output fci_pkg::cmd_t            cmd
);
	import fci_pkg::*;

	state_t state_q, state_n;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = out_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_n;
	end

	// Output register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (rsp_ready)
			out_valid_q <= 1'b0;
	end

	// Next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (req_opcode == OP_DUTY)
						state_n = ST_MUL;
					else if (req_opcode == OP_SPEED)
						state_n = ST_RDL;
				end
			end
			ST_MUL:  state_n = ST_TGT;
			ST_TGT:  state_n = ST_CHK;
			ST_CHK: begin
				if (sts.t_zero)
					state_n = ST_DONE;
				else if (sts.more)
					state_n = ST_SRD;
				else
					state_n = ST_RDL;
			end
			ST_SRD:  state_n = ST_SCMP;
			ST_SCMP: state_n = sts.more_nxt ? ST_SRD : ST_RDL;
			ST_RDL:  state_n = ST_RDH;
			ST_RDH:  state_n = ST_SLP;
			ST_SLP:  state_n = ST_DEC;
			ST_DEC: begin
				if (sts.s_zero)
					state_n = ST_DONE;
				else if (sts.op_speed)
					state_n = ST_FIN2;
				else
					state_n = ST_ABS;
			end
			ST_ABS:  state_n = ST_PREP;
			ST_PREP: state_n = ST_DCHK;
			ST_DCHK: state_n = ST_DIV;
			ST_DIV:  state_n = sts.div_last ? ST_FIN1 : ST_DIV;
			ST_FIN1: state_n = ST_DONE;
			ST_FIN2: state_n = ST_DONE;
			ST_DONE: begin
				if (slot_free)
					state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd.step     = STEP_NONE;
		cmd.out_load = 1'b0;
		case (state_q)
			ST_IDLE: cmd.step = req_valid ? STEP_LOAD : STEP_NONE;
			ST_MUL:  cmd.step = STEP_MUL;
			ST_TGT:  cmd.step = STEP_TGT;
			ST_SRD:  cmd.step = STEP_SRD;
			ST_SCMP: cmd.step = STEP_SCMP;
			ST_RDL:  cmd.step = STEP_RDL;
			ST_RDH:  cmd.step = STEP_RDH;
			ST_SLP:  cmd.step = STEP_SLP;
			ST_DEC:  cmd.step = STEP_DEC;
			ST_ABS:  cmd.step = STEP_ABS;
			ST_PREP: cmd.step = STEP_PREP;
			ST_DCHK: cmd.step = STEP_DCHK;
			ST_DIV:  cmd.step = STEP_DIV;
			ST_FIN1: cmd.step = STEP_FIN1;
			ST_FIN2: cmd.step = STEP_FIN2;
			ST_DONE: cmd.out_load = slot_free;
			default: cmd.step = STEP_NONE;
		endcase
	end

	`FCI_ASSERT_SAME(a_no_overwrite, cmd.out_load, !out_valid_q || rsp_ready,
		"result loaded over an untaken result")
	`FCI_ASSERT_NEXT(a_div_runs, state_q == ST_DIV && !sts.div_last, state_q == ST_DIV,
		"divider left before its last step")
	`FCI_ASSERT_NEXT(a_duty_starts, req_valid && req_ready && req_opcode == OP_DUTY,
		state_q == ST_MUL, "duty request did not start with the target product")

endmodule

// ===== rtl/core/fci_dp.sv =====
`include "fan_curve_interpolator_macros.svh"

module fci_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fci_pkg::cmd_t                 cmd,
	output fci_pkg::sts_t                 sts,
	input  logic [fci_pkg::OPCODE_W-1:0]  opcode,
	input  logic [fci_pkg::ENTRY_W-1:0]   entry_index,
	input  logic [fci_pkg::SPEED_W-1:0]   entry_speed,
	input  logic [fci_pkg::DEMAND_W-1:0]  demand,
	input  logic [fci_pkg::DUTY_W-1:0]    duty_in,
	input  logic                          cfg_we,
	input  logic [fci_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fci_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic [fci_pkg::DUTY_W-1:0]    duty_out,
	output logic [fci_pkg::SPEED_W-1:0]   speed_out
);
	import fci_pkg::*;

	// Configuration
	logic [SPEED_W-1:0] min_speed_q, max_speed_q;
	logic [DUTY_W-1:0]  start_duty_q;

	// Item and working registers
	logic                     op_speed_q;
	logic [DEMAND_W-1:0]      demand_q;
	logic [DUTY_SHIFT-1:0]    frac_q;
	logic [IDX_W-1:0]         lo_q, hi_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [T_W-1:0]    t_q, num_q;
	logic [SPEED_W-1:0]       tl_q, th_q;
	logic [SLOPE_W-1:0]       as_q;
	logic                     s_neg_q, neg_q, big_q;
	logic [ANUM_W-1:0]        anum_q;
	logic [A_W-1:0]           a_q;
	logic [QUO_W-1:0]         abits_q, quo_q;
	logic [REM_W-1:0]         rem_q;
	logic [DIV_CNT_W-1:0]     cnt_q;
	logic signed [P2_W-1:0]   prod2_q;
	logic [DUTY_W-1:0]        res_duty_q, duty_out_q;
	logic [SPEED_W-1:0]       res_speed_q, speed_out_q;

	// Table memory
	logic               ram_we, ram_re;
	logic [IDX_W-1:0]   ram_raddr;
	logic [SPEED_W-1:0] ram_rdata;

	// Combinational helpers
	logic [DUTY_W-1:0]         start_idx, duty_idx;
	logic [IDX_W-1:0]          start_lo, duty_lo, mid, lo_n, hi_n;
	logic                      go_hi;
	logic signed [SPEED_W:0]   diff_ms, diff_rd, diff_tab;
	logic [SPEED_W:0]          mag_rd;
	logic signed [T_W-1:0]     t_sum;
	logic [N_W-1:0]            n_sum;
	logic [REM_W:0]            trial;
	logic                      qbit;
	logic [QUO_W-1:0]          qeff;
	logic signed [DUTY_CALC_W-1:0] base_d, q_d, duty_d;
	logic signed [P2_W-1:0]    speed_sum;

	assign ram_we = (cmd.step == STEP_LOAD) && (opcode == OP_WRITE)
		&& (32'(entry_index) < POINTS);

	fci_ram #(.WIDTH(SPEED_W), .DEPTH(POINTS)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (entry_index[IDX_W-1:0]),
		.wdata (entry_speed),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Search bracket starts
	always_comb begin
		start_idx = start_duty_q >> DUTY_SHIFT;
		duty_idx  = duty_in >> DUTY_SHIFT;
		start_lo  = (32'(start_idx) > POINTS - 1) ? IDX_LAST : start_idx[IDX_W-1:0];
		duty_lo   = (32'(duty_idx) > POINTS - 1) ? IDX_LAST : duty_idx[IDX_W-1:0];
	end

	// Bisection step
	always_comb begin
		mid   = IDX_W'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
		go_hi = $signed({{(T_W-SPEED_W-FRAC_W){1'b0}}, ram_rdata, {FRAC_W{1'b0}}}) >= t_q;
		lo_n  = go_hi ? lo_q : mid;
		hi_n  = go_hi ? mid : hi_q;
	end

	// Table read address
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = lo_q;
		case (cmd.step)
			STEP_SRD: begin
				ram_re    = 1'b1;
				ram_raddr = mid;
			end
			STEP_RDL: begin
				ram_re    = 1'b1;
				ram_raddr = lo_q;
			end
			STEP_RDH: begin
				ram_re    = 1'b1;
				ram_raddr = hi_q;
			end
			default: ram_re = 1'b0;
		endcase
	end

	// Arithmetic
	always_comb begin
		diff_ms  = $signed({1'b0, max_speed_q}) - $signed({1'b0, min_speed_q});
		t_sum    = $signed({{(T_W-SPEED_W-FRAC_W){1'b0}}, min_speed_q, {FRAC_W{1'b0}}})
			+ T_W'(prod_q);
		diff_rd  = $signed({1'b0, ram_rdata}) - $signed({1'b0, tl_q});
		mag_rd   = diff_rd < 0 ? $unsigned(-diff_rd) : $unsigned(diff_rd);
		diff_tab = $signed({1'b0, th_q}) - $signed({1'b0, tl_q});
		n_sum    = {1'b0, anum_q, 1'b0} + N_W'({as_q, {FRAC_W{1'b0}}});
		trial    = {rem_q, abits_q[QUO_W-1]};
		qbit     = trial >= {1'b0, as_q};
		qeff     = big_q ? '1 : quo_q;
		base_d   = $signed(DUTY_CALC_W'({lo_q, {DUTY_SHIFT{1'b0}}}));
		q_d      = $signed(DUTY_CALC_W'(qeff));
		duty_d   = neg_q ? base_d - q_d : base_d + q_d;
		speed_sum = $signed(P2_W'(tl_q)) + (prod2_q >>> DUTY_SHIFT);
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_speed_q  <= '0;
			max_speed_q  <= '1;
			start_duty_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_SPEED:  min_speed_q  <= cfg_data[SPEED_W-1:0];
				CFG_MAX_SPEED:  max_speed_q  <= cfg_data[SPEED_W-1:0];
				CFG_START_DUTY: start_duty_q <= cfg_data[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		case (cmd.step)
			STEP_LOAD: begin
				op_speed_q  <= (opcode == OP_SPEED);
				demand_q    <= demand;
				frac_q      <= duty_in[DUTY_SHIFT-1:0];
				res_duty_q  <= '0;
				res_speed_q <= '0;
				if (opcode == OP_SPEED) begin
					lo_q <= duty_lo;
					hi_q <= (duty_lo == IDX_LAST) ? IDX_LAST : duty_lo + IDX_W'(1);
				end else begin
					lo_q <= start_lo;
					hi_q <= IDX_LAST;
				end
			end
			STEP_MUL: prod_q <= diff_ms * $signed({1'b0, demand_q});
			STEP_TGT: t_q <= t_sum;
			STEP_SCMP: begin
				lo_q <= lo_n;
				hi_q <= hi_n;
			end
			STEP_RDH: tl_q <= ram_rdata;
			STEP_SLP: begin
				th_q    <= ram_rdata;
				as_q    <= mag_rd[SPEED_W-1:DUTY_SHIFT];
				s_neg_q <= diff_rd < 0;
			end
			STEP_DEC: begin
				num_q   <= t_q - $signed({{(T_W-SPEED_W-FRAC_W){1'b0}}, tl_q, {FRAC_W{1'b0}}});
				prod2_q <= $signed({1'b0, frac_q}) * diff_tab;
				// flat segment answers, replaced later when the slope is non-zero
				if (op_speed_q)
					res_speed_q <= tl_q;
				else
					res_duty_q <= sat_duty(base_d);
			end
			STEP_ABS: begin
				anum_q <= num_q < 0 ? ANUM_W'(-num_q) : ANUM_W'(num_q);
				neg_q  <= (num_q < 0) ^ s_neg_q;
			end
			STEP_PREP: a_q <= n_sum[N_W-1:FRAC_W+1];
			STEP_DCHK: begin
				// quotients of 512 and up saturate the duty either way
				big_q   <= {1'b0, a_q} >= {as_q, {QUO_W{1'b0}}};
				rem_q   <= REM_W'(a_q[A_W-1:QUO_W]);
				abits_q <= a_q[QUO_W-1:0];
				quo_q   <= '0;
				cnt_q   <= '0;
			end
			STEP_DIV: begin
				rem_q   <= qbit ? REM_W'(trial - {1'b0, as_q}) : trial[REM_W-1:0];
				quo_q   <= {quo_q[QUO_W-2:0], qbit};
				abits_q <= {abits_q[QUO_W-2:0], 1'b0};
				cnt_q   <= cnt_q + DIV_CNT_W'(1);
			end
			STEP_FIN1: res_duty_q <= sat_duty(duty_d);
			STEP_FIN2: res_speed_q <= speed_sum[SPEED_W-1:0];
			default: ;
		endcase
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			duty_out_q  <= res_duty_q;
			speed_out_q <= res_speed_q;
		end
	end

	assign duty_out  = duty_out_q;
	assign speed_out = speed_out_q;

	// Status
	always_comb begin
		sts.t_zero   = (t_q == '0);
		sts.more     = (hi_q - lo_q) > IDX_W'(1);
		sts.more_nxt = (hi_n - lo_n) > IDX_W'(1);
		sts.s_zero   = (as_q == '0);
		sts.op_speed = op_speed_q;
		sts.div_last = (cnt_q == DIV_LAST);
	end

	`FCI_ASSERT_SAME(a_bracket_open, cmd.step == STEP_SCMP, hi_q > lo_q + IDX_W'(1),
		"search compare on a closed bracket")

endmodule

// ===== rtl/core/fan_curve_interpolator.sv =====
// Fan curve interpolator: a table of measured fan speeds, one per duty step.
// Channels (valid/ready, transfer when both high):
//   req - opcode 0 writes table entry entry_index with entry_speed;
//         opcode 1 turns a demand fraction into a duty; opcode 2 turns duty_in
//         into a speed; opcode 3 is dropped. Opcodes 1 and 2 give one result.
//   rsp - duty_out / speed_out; the unused field of a result reads zero.
//   cfg - writes min_speed (0), max_speed (1), start_duty (2); always ready.
// One item is worked on at a time; req is ready only while the controller
// is idle. A write completes on its transfer. Speed from duty reads the two
// segment entries and interpolates; a flat segment returns the lower entry.
// Duty from demand: a bisection of up to four halvings, each a read and a
// compare, then a nine-step restoring divider; a zero target skips both.
// Results sit in an output register: the next request is taken while a
// result waits, and a finished item holds in its last state until rsp frees.
// Reset restores the register defaults and empties the output; table
// entries keep no reset value and must be written before they are used.
module fan_curve_interpolator (
	input logic       clk,
	input logic       arst_n,
	fci_req_if.sink   req,
	fci_rsp_if.source rsp,
	fci_cfg_if.sink   cfg
);
	import fci_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg.ready = 1'b1;

	fci_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_opcode (req.opcode),
		.req_ready  (req.ready),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	fci_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.opcode      (req.opcode),
		.entry_index (req.entry_index),
		.entry_speed (req.entry_speed),
		.demand      (req.demand),
		.duty_in     (req.duty_in),
		.cfg_we      (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.duty_out    (rsp.duty_out),
		.speed_out   (rsp.speed_out)
	);

endmodule
